>>> sv/bloom_filter_double_hashing_core_defines.svh
// Assertion helpers; clock and reset are taken from the enclosing module.
`ifndef BLOOM_FILTER_DOUBLE_HASHING_CORE_DEFINES_SVH
`define BLOOM_FILTER_DOUBLE_HASHING_CORE_DEFINES_SVH

// Same-cycle implication.
`define BFDH_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BFDH_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/bfdh_pkg.sv
package bfdh_pkg;

   localparam int MAX_BITS    = 1024;
   localparam int MAX_HASHES  = 16;
   localparam int IDX_W       = $clog2(MAX_BITS);
   localparam int M_W         = IDX_W + 1;
   localparam int K_W         = $clog2(MAX_HASHES) + 1;
   localparam int HASH_W      = 64;

   // filter array held as rows of a small RAM
   localparam int ROW_W       = 32;
   localparam int ROWS        = MAX_BITS / ROW_W;
   localparam int ROW_AW      = $clog2(ROWS);
   localparam int COL_W       = $clog2(ROW_W);

   // divider: dividend bits retired per cycle
   localparam int DIV_RADIX_W = 4;
   localparam int DIV_PASSES  = HASH_W / DIV_RADIX_W;
   localparam int DIV_CNT_W   = $clog2(DIV_PASSES);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // register map (word index)
   localparam logic REG_BIT_COUNT  = 1'b0;
   localparam logic REG_HASH_COUNT = 1'b1;

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   typedef struct packed {
      logic              is_query;
      logic [HASH_W-1:0] hash_first;
      logic [HASH_W-1:0] hash_second;
   } item_type;

   typedef struct packed {
      logic [M_W-1:0] m;
      logic [K_W-1:0] k;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] dividend;
      logic [M_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [IDX_W-1:0] rem;
   } div_rsp_type;

endpackage

>>> sv/bfdh_ram.sv
module bfdh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/bfdh_front.sv
// Input side: decodes the word and holds it in a short queue for the back end.
module bfdh_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [2*bfdh_pkg::HASH_W-1:0] req_tdata,
   input  logic                       req_tuser,
   output logic                       q_valid,
   output bfdh_pkg::item_type         q_item,
   input  logic                       q_pop
);

   bfdh_pkg::item_type                entry_ff [bfdh_pkg::QUEUE_DEPTH];
   bfdh_pkg::item_type                entry_in [bfdh_pkg::QUEUE_DEPTH];
   logic [bfdh_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [bfdh_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [bfdh_pkg::QCNT_W-1:0]       count_ff, count_in;
   bfdh_pkg::item_type                item_dec;
   logic                              push;
   logic                              pop;

   always_comb begin
      item_dec.is_query    = (req_tuser == bfdh_pkg::KIND_QUERY);
      item_dec.hash_first  = req_tdata[bfdh_pkg::HASH_W-1:0];
      item_dec.hash_second = req_tdata[2*bfdh_pkg::HASH_W-1:bfdh_pkg::HASH_W];
   end

   assign req_tready = (count_ff != bfdh_pkg::QCNT_W'(bfdh_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = item_dec;
         wr_ptr_in           = wr_ptr_ff + bfdh_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + bfdh_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + bfdh_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - bfdh_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> sv/bfdh_div.sv
// 64-bit by 11-bit remainder, four restoring steps a cycle.
module bfdh_div (
   input  logic                  clock,
   input  logic                  reset,
   input  bfdh_pkg::div_req_type div_req,
   output bfdh_pkg::div_rsp_type div_rsp
);

   logic [bfdh_pkg::HASH_W-1:0]    shift_ff, shift_in;
   logic [bfdh_pkg::IDX_W-1:0]     rem_ff, rem_in;
   logic [bfdh_pkg::M_W-1:0]       divisor_ff, divisor_in;
   logic [bfdh_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [bfdh_pkg::IDX_W-1:0]     rem_step;

   function automatic logic [bfdh_pkg::IDX_W-1:0] digit_steps(
      input logic [bfdh_pkg::IDX_W-1:0]       r_start,
      input logic [bfdh_pkg::DIV_RADIX_W-1:0] bits,
      input logic [bfdh_pkg::M_W-1:0]         d
   );
      logic [bfdh_pkg::IDX_W-1:0] r;
      logic [bfdh_pkg::M_W-1:0]   t;
      r = r_start;
      for (int j = bfdh_pkg::DIV_RADIX_W - 1; j >= 0; j--) begin
         t = {r, bits[j]};
         if (t >= d) begin
            t = t - d;
         end
         r = t[bfdh_pkg::IDX_W-1:0];
      end
      return r;
   endfunction

   assign rem_step = digit_steps(rem_ff,
      shift_ff[bfdh_pkg::HASH_W-1:bfdh_pkg::HASH_W-bfdh_pkg::DIV_RADIX_W], divisor_ff);

   always_comb begin
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (div_req.start) begin
         shift_in   = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         shift_in = shift_ff << bfdh_pkg::DIV_RADIX_W;
         rem_in   = rem_step;
         cnt_in   = cnt_ff + bfdh_pkg::DIV_CNT_W'(1);
         if (cnt_ff == bfdh_pkg::DIV_CNT_W'(bfdh_pkg::DIV_PASSES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      cnt_ff     <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

>>> sv/bfdh_back.sv
`include "bloom_filter_double_hashing_core_defines.svh"

// Probe sequencer: one item at a time, one divide and one row read per probe, with a write-back for inserts.
module bfdh_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bfdh_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  bfdh_pkg::item_type    q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_present
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_CHK  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]                   state_ff, state_in;
   logic [bfdh_pkg::HASH_W-1:0]  probe_ff, probe_in;
   logic [bfdh_pkg::HASH_W-1:0]  step_ff, step_in;
   logic                         is_query_ff, is_query_in;
   logic [bfdh_pkg::K_W-1:0]     cnt_ff, cnt_in;
   logic                         result_ff, result_in;
   logic                         out_valid_ff, out_valid_in;
   logic                         out_present_ff, out_present_in;
   logic [bfdh_pkg::ROWS-1:0]    row_valid_ff, row_valid_in;

   bfdh_pkg::div_req_type        div_req;
   bfdh_pkg::div_rsp_type        div_rsp;
   logic                         ram_we;
   logic [bfdh_pkg::ROW_W-1:0]   ram_wdata;
   logic [bfdh_pkg::ROW_W-1:0]   ram_rdata;
   logic [bfdh_pkg::ROW_W-1:0]   row_word;
   logic [bfdh_pkg::ROW_AW-1:0]  row;
   logic [bfdh_pkg::COL_W-1:0]   col;
   logic [bfdh_pkg::K_W-1:0]     cnt_next;
   logic [bfdh_pkg::HASH_W-1:0]  probe_next;
   logic                         hit_bit;
   logic                         out_free;

   assign row        = div_rsp.rem[bfdh_pkg::IDX_W-1:bfdh_pkg::COL_W];
   assign col        = div_rsp.rem[bfdh_pkg::COL_W-1:0];
   assign row_word   = row_valid_ff[row] ? ram_rdata : '0;
   assign hit_bit    = row_word[col];
   assign cnt_next   = cnt_ff + bfdh_pkg::K_W'(1);
   assign probe_next = probe_ff + step_ff;
   assign out_free   = !out_valid_ff || rsp_tready;

   bfdh_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   bfdh_ram #(
      .WIDTH (bfdh_pkg::ROW_W),
      .DEPTH (bfdh_pkg::ROWS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (row),
      .wdata (ram_wdata),
      .raddr (row),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in         = state_ff;
      probe_in         = probe_ff;
      step_in          = step_ff;
      is_query_in      = is_query_ff;
      cnt_in           = cnt_ff;
      result_in        = result_ff;
      out_valid_in     = out_valid_ff && !rsp_tready;
      out_present_in   = out_present_ff;
      row_valid_in     = row_valid_ff;
      q_pop            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = probe_ff;
      div_req.divisor  = cfg.m;
      ram_we           = 1'b0;
      ram_wdata        = row_word | (bfdh_pkg::ROW_W'(1) << col);
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop            = 1'b1;
               probe_in         = q_item.hash_first;
               step_in          = q_item.hash_second;
               is_query_in      = q_item.is_query;
               cnt_in           = '0;
               div_req.start    = 1'b1;
               div_req.dividend = q_item.hash_first;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (!is_query_ff) begin
               ram_we            = 1'b1;
               row_valid_in[row] = 1'b1;
            end
            if (is_query_ff && !hit_bit) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else if (cnt_next == cfg.k) begin
               result_in = is_query_ff;
               state_in  = ST_DONE;
            end else begin
               cnt_in           = cnt_next;
               probe_in         = probe_next;
               div_req.start    = 1'b1;
               div_req.dividend = probe_next;
               state_in         = ST_DIV;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_present_in = result_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      probe_ff       <= probe_in;
      step_ff        <= step_in;
      is_query_ff    <= is_query_in;
      cnt_ff         <= cnt_in;
      result_ff      <= result_in;
      out_present_ff <= out_present_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         row_valid_ff <= row_valid_in;
      end
   end

   assign rsp_tvalid  = out_valid_ff;
   assign rsp_present = out_present_ff;

   `BFDH_ASSERT_IMP(a_rem_range, state_ff == ST_CHK, {1'b0, div_rsp.rem} < cfg.m, "bad index")
   `BFDH_ASSERT_IMP(a_done_in_div, div_rsp.done, state_ff == ST_DIV, "done outside divide")
   `BFDH_ASSERT_IMP(a_probe_count, state_ff == ST_CHK, cnt_ff < cfg.k, "count past k")
   `BFDH_ASSERT_NXT(a_pop_starts, q_pop, state_ff == ST_DIV, "pop without divide")

endmodule

>>> sv/bloom_filter_double_hashing_core.sv
// Bloom filter with double hashing over a 1024-cell bit array that reset clears.
// Each input word is an insert or a query carrying two 64-bit base hashes h1, h2;
// probe i uses cell ((h1 + i*h2) mod 2^64) mod m, for i = 0 .. k-1. Exactly one
// result word comes back per input word: maybe_present is 1 only for a query whose
// k cells are all set, and always 0 for an insert. m (bit_count, 0 reads as 1,
// capped at 1024) and k (probe count, 0 reads as 1, capped at 16) sit on the
// APB-style port at byte addresses 0 and 4; write them only while the core is idle.
// Cells beyond m keep their contents when m shrinks. Each probe is one divide in
// the radix-16 remainder unit over the 64-bit probe, then a row read of the
// filter RAM and, for an insert, a write-back of that row; a query stops at the
// first clear cell. Items are handled one at a time by the back end, while a
// two-word input queue and the output register let either side stall
// independently. The filter RAM needs no clearing pass: a per-row valid flag,
// cleared by reset, makes an unwritten row read as all zero. Reset sets k = 5.
module bloom_filter_double_hashing_core (
   input  logic         clock,
   input  logic         reset,
   // request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] hash_first, [127:64] hash_second
   input  logic         req_tuser,   // [0] req_type: 0 insert, 1 query
   // response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [0] maybe_present, [7:1] zero
   // register port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [bfdh_pkg::M_W-1:0] bit_count_ff, bit_count_in;
   logic [bfdh_pkg::K_W-1:0] hash_num_ff, hash_num_in;
   logic                     csr_write;
   logic                     csr_index;
   bfdh_pkg::cfg_type        cfg;
   logic                     q_valid;
   logic                     q_pop;
   bfdh_pkg::item_type       q_item;
   logic                     rsp_present;

   // register port: word index is paddr[2], byte offset ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      bit_count_in = bit_count_ff;
      hash_num_in  = hash_num_ff;
      if (csr_write) begin
         case (csr_index)
            bfdh_pkg::REG_BIT_COUNT:  bit_count_in = csr_pwdata[bfdh_pkg::M_W-1:0];
            bfdh_pkg::REG_HASH_COUNT: hash_num_in  = csr_pwdata[bfdh_pkg::K_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         bfdh_pkg::REG_BIT_COUNT:  csr_prdata = 32'(bit_count_ff);
         bfdh_pkg::REG_HASH_COUNT: csr_prdata = 32'(hash_num_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff <= bfdh_pkg::M_W'(bfdh_pkg::MAX_BITS);
         hash_num_ff  <= bfdh_pkg::K_W'(5);
      end else begin
         bit_count_ff <= bit_count_in;
         hash_num_ff  <= hash_num_in;
      end
   end

   // effective m and k: zero reads as one, large values saturate
   always_comb begin
      if (bit_count_ff == '0) begin
         cfg.m = bfdh_pkg::M_W'(1);
      end else if (bit_count_ff > bfdh_pkg::M_W'(bfdh_pkg::MAX_BITS)) begin
         cfg.m = bfdh_pkg::M_W'(bfdh_pkg::MAX_BITS);
      end else begin
         cfg.m = bit_count_ff;
      end
      if (hash_num_ff == '0) begin
         cfg.k = bfdh_pkg::K_W'(1);
      end else if (hash_num_ff > bfdh_pkg::K_W'(bfdh_pkg::MAX_HASHES)) begin
         cfg.k = bfdh_pkg::K_W'(bfdh_pkg::MAX_HASHES);
      end else begin
         cfg.k = hash_num_ff;
      end
   end

   bfdh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   bfdh_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_present (rsp_present)
   );

   assign rsp_tdata = {7'b0, rsp_present};

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

   localparam int   MAX_BITS       = bfdh_pkg::MAX_BITS;
   localparam int   MAX_HASHES     = bfdh_pkg::MAX_HASHES;
   localparam int   IDX_W          = bfdh_pkg::IDX_W;
   localparam int   M_W            = bfdh_pkg::M_W;
   localparam int   K_W            = bfdh_pkg::K_W;
   localparam logic KIND_INSERT    = bfdh_pkg::KIND_INSERT;
   localparam logic KIND_QUERY     = bfdh_pkg::KIND_QUERY;
   localparam logic REG_BIT_COUNT  = bfdh_pkg::REG_BIT_COUNT;
   localparam logic REG_HASH_COUNT = bfdh_pkg::REG_HASH_COUNT;

   // Timeout, in clock cycles. The slowest correct run is about 980 words, all at
   // k = 16, with every word waiting out the longest sender gap and receiver
   // stall, plus the long output hold; this limit leaves a wide margin over that.
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int GAP_MAX     = 17;
   localparam int HOLD_CYCLES = 1500;
   localparam int SETTLE      = 400;   // more than one word at k = 16

   // TYPED marks a directed row whose answer is written into the row itself.
   localparam logic PREDICT = 1'b0;
   localparam logic TYPED   = 1'b1;

   typedef enum int {PLAIN, PAUSE_MIDWAY, HOLD_MIDWAY} phase_kind_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] h1;
      logic [63:0] h2;
      logic        how;       // PREDICT or TYPED
      logic        present;   // used only when how is TYPED
   } dir_row_type;

   // Rows run at the reset setting, m = 1024 and k = 5, on an empty filter.
   localparam int DIR_ROWS = 22;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // an empty filter answers no, whatever the key
      '{KIND_QUERY,  64'h0, 64'h0, TYPED, 1'b0},
      '{KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b0},
      // h2 = 0, so all five probes land on cell 0
      '{KIND_INSERT, 64'h0, 64'h0, TYPED, 1'b0},
      '{KIND_QUERY,  64'h0, 64'h0, TYPED, 1'b1},
      '{KIND_QUERY,  64'h0, 64'h1, PREDICT, 1'b0},
      // h2 of all ones steps the probe downwards by one each time
      '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b0},
      '{KIND_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b1},
      '{KIND_QUERY,  64'h400, 64'h0, PREDICT, 1'b0},
      '{KIND_INSERT, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, TYPED, 1'b0},
      '{KIND_QUERY,  64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555, TYPED, 1'b1},
      '{KIND_QUERY,  64'h8000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA, PREDICT, 1'b0},
      // probe sum wraps past 2^64 straight onto cell 0
      '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FC00, 64'h400, TYPED, 1'b0},
      '{KIND_INSERT, 64'h3, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b0},
      // first cells set, a later one clear: the query stops there
      '{KIND_QUERY,  64'h0, 64'h1, PREDICT, 1'b0},
      '{KIND_QUERY,  64'h5, 64'hFFFF_FFFF_FFFF_FFFF, PREDICT, 1'b0},
      '{KIND_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, TYPED, 1'b0},
      '{KIND_QUERY,  64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, TYPED, 1'b1},
      '{KIND_QUERY,  64'h0123_4567_89AB_CDEF, 64'h0, PREDICT, 1'b0},
      '{KIND_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, TYPED, 1'b0},
      '{KIND_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, PREDICT, 1'b0},
      '{KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, TYPED, 1'b0},
      '{KIND_QUERY,  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, TYPED, 1'b1}
   };

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata   = '0;     // [63:0] hash_first, [127:64] hash_second
   logic         req_tuser   = 1'b0;   // [0] req_type
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [7:0]   rsp_tdata;            // [0] maybe_present, [7:1] zero
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [2:0]   csr_paddr   = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Own copy of the filter and of the two registers.
   logic           filter_cells [MAX_BITS];
   logic [M_W-1:0] bits_reg   = 11'd1024;
   logic [K_W-1:0] hashes_reg = 5'd5;

   logic           present_q [$];       // expected maybe_present, oldest first
   logic [127:0]   inserted_keys [$];   // {h2, h1} of recent inserts, for queries that hit
   int             tx_gap_max  = GAP_MAX;
   int             rx_gap_max  = GAP_MAX;
   int             rsp_hold    = 0;     // one-off receiver hold-off, in cycles
   int             mismatches  = 0;
   int             cycle_count = 0;
   logic           want;

   bloom_filter_double_hashing_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[bloom_filter_double_hashing_core] ERROR");
         $finish;
      end
   end

   // Applies one word to the filter copy and returns the expected flag.
   // The registers are zero-floored and capped the same way the core does it.
   function automatic logic filter_probe(input logic kind, input logic [63:0] h1,
                                         input logic [63:0] h2);
      logic [63:0] m_eff;
      logic [63:0] probe;
      logic [63:0] slot;
      int          k_eff;
      logic        hit;
      m_eff = 64'(bits_reg);
      if (m_eff == 64'd0) m_eff = 64'd1;
      if (m_eff > 64'(MAX_BITS)) m_eff = 64'(MAX_BITS);
      k_eff = int'(hashes_reg);
      if (k_eff == 0) k_eff = 1;
      if (k_eff > MAX_HASHES) k_eff = MAX_HASHES;
      probe = h1;
      hit   = 1'b1;
      for (int i = 0; i < k_eff; i++) begin
         slot = probe % m_eff;
         if (kind == KIND_QUERY) begin
            if (!filter_cells[slot[IDX_W-1:0]]) begin
               hit = 1'b0;
               break;
            end
         end else begin
            filter_cells[slot[IDX_W-1:0]] = 1'b1;
         end
         probe = probe + h2;
      end
      return (kind == KIND_QUERY) && hit;
   endfunction

   // Hashes lean towards zero, all ones and the values either side of the wrap.
   function automatic logic [63:0] rand_hash();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return {32'd0, $urandom_range(0, 4095)};
         3: return ~{32'd0, $urandom_range(0, 4095)};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Offers one word and waits for it to be taken. tvalid is left high
   // afterwards, so back-to-back words need no extra edge.
   task automatic send_word(input logic kind, input logic [63:0] h1, input logic [63:0] h2,
                            input logic how, input logic typed_present);
      int   gap;
      logic guess;
      gap = int'($urandom_range(0, tx_gap_max));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {h2, h1};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      guess = filter_probe(kind, h1, h2);
      present_q = {present_q, ((how == TYPED) ? typed_present : guess)};
   endtask

   // Stops offering and waits until every outstanding result is back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (present_q.size() != 0);
   endtask

   task automatic csr_write(input logic reg_idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (reg_idx == REG_BIT_COUNT) bits_reg = value[M_W-1:0];
      else hashes_reg = value[K_W-1:0];
   endtask

   // Inserts of fresh keys, plus queries where most keys come from recent
   // inserts. Within one register setting those queries hit.
   task automatic send_random();
      logic         kind;
      logic [63:0]  h1;
      logic [63:0]  h2;
      logic [127:0] key;
      kind = ($urandom_range(0, 99) < 55) ? KIND_QUERY : KIND_INSERT;
      if (kind == KIND_QUERY && inserted_keys.size() != 0 && $urandom_range(0, 99) < 60) begin
         key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
         h1  = key[63:0];
         h2  = key[127:64];
      end else begin
         h1 = rand_hash();
         h2 = rand_hash();
      end
      if (kind == KIND_INSERT) begin
         inserted_keys = {inserted_keys, {h2, h1}};
         if (inserted_keys.size() > 48) void'(inserted_keys.pop_front());
      end
      send_word(kind, h1, h2, PREDICT, 1'b0);
   endtask

   // One setting of the registers followed by a run of random words. Writes
   // only happen after the core has gone quiet.
   task automatic run_phase(input logic [31:0] bits_val, input logic [31:0] hashes_val,
                            input bit do_cfg, input int n_words, input phase_kind_type kind);
      drain_results();
      if (do_cfg) begin
         csr_write(REG_BIT_COUNT, bits_val);
         csr_write(REG_HASH_COUNT, hashes_val);
      end
      // about a quarter of phases run with no idling on one side or the other
      tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
      for (int i = 0; i < n_words; i++) begin
         if (i == n_words / 2) begin
            if (kind == PAUSE_MIDWAY) begin
               drain_results();
            end else if (kind == HOLD_MIDWAY) begin
               // receiver goes quiet while words keep coming flat out
               rsp_hold   = HOLD_CYCLES;
               tx_gap_max = 0;
            end
         end
         send_random();
      end
   endtask

   function automatic logic [31:0] rand_bits_val();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[M_W-1:0] = '0;
         1: v[M_W-1:0] = M_W'($urandom_range(MAX_BITS + 1, 2047));
         default: v[M_W-1:0] = M_W'($urandom_range(1, MAX_BITS));
      endcase
      return v;
   endfunction

   function automatic logic [31:0] rand_hashes_val();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0: v[K_W-1:0] = '0;
         1: v[K_W-1:0] = K_W'($urandom_range(MAX_HASHES + 1, 31));
         default: v[K_W-1:0] = K_W'($urandom_range(1, MAX_HASHES));
      endcase
      return v;
   endfunction

   // Result side: a random stall before each word, or the one-off long hold.
   initial begin
      int wait_cycles;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            wait_cycles = rsp_hold;
            rsp_hold    = 0;
         end else begin
            wait_cycles = int'($urandom_range(0, rx_gap_max));
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // Result checker. Signals are sampled just after the edge, before any
   // nonblocking update lands, so this sees what the core saw.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (present_q.size() == 0) begin
            $display("%0t: result word with nothing outstanding: expected none, got %0b",
                     $time, rsp_tdata[0]);
            mismatches++;
         end else begin
            want = present_q.pop_front();
            if (rsp_tdata[0] !== want) begin
               $display("%0t: maybe_present mismatch: expected %0b, got %0b",
                        $time, want, rsp_tdata[0]);
               mismatches++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < MAX_BITS; i++) filter_cells[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIR_ROWS; r++) begin
         send_word(DIRECTED[r].kind, DIRECTED[r].h1, DIRECTED[r].h2,
                   DIRECTED[r].how, DIRECTED[r].present);
      end

      run_phase(32'd0, 32'd0, 1'b0, 80, PLAIN);          // reset setting
      run_phase(32'd0, 32'd0, 1'b1, 60, PAUSE_MIDWAY);   // zero reads as one: all on cell 0
      run_phase(32'd2047, 32'd31, 1'b1, 70, HOLD_MIDWAY); // both capped: m = 1024, k = 16
      run_phase(32'd1, 32'd16, 1'b1, 40, PLAIN);
      run_phase(32'd1024, 32'd1, 1'b1, 100, PLAIN);
      run_phase(32'd16, 32'd3, 1'b1, 80, PLAIN);         // shrink m, upper cells kept
      // junk above the field widths; masks back to m = 1024, k = 5
      run_phase(32'hFFFF_F400, 32'hFFFF_FFE5, 1'b1, 80, PLAIN);
      for (int p = 0; p < 6; p++) begin
         run_phase(rand_bits_val(), rand_hashes_val(), 1'b1, 75, PLAIN);
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("[bloom_filter_double_hashing_core] OK");
      end else begin
         $display("[bloom_filter_double_hashing_core] ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/bfdh_pkg.sv
sv/bfdh_ram.sv
sv/bfdh_front.sv
sv/bfdh_div.sv
sv/bfdh_back.sv
sv/bloom_filter_double_hashing_core.sv
tb/sv/tb_top.sv
